// ===== rtl/fk_pkg.sv =====
// Shared constants, types and the arctangent table of the arm kinematics block.
package fk_pkg;

	localparam int FK_ANGLE_BITS    = 16;
	localparam int FK_POS_BITS      = 20;
	localparam int FK_CORDIC_STAGES = 16;
	localparam int FK_MAX_STAGES    = 24;

	localparam int FK_REG_BITS   = 18;
	localparam int FK_INDEX_BITS = 3;
	localparam int FK_ANGLE_WIDEN = 17;
	localparam int FK_TRIG_FRAC  = 30;
	localparam int FK_TRIG_W     = 34;
	localparam int FK_POS_W      = 26;
	localparam int FK_K_W        = 10;
	localparam int FK_RED_W      = 48;

	localparam longint FK_PI       = 64'sd3373259426;
	localparam longint FK_HALF_PI  = 64'sd1686629713;
	localparam longint FK_TWO_PI   = 64'sd6746518852;
	localparam longint FK_GAIN     = 64'sd652032874;
	localparam int     FK_RECIP_SH = 40;
	// 2^(RECIP_SH + ANGLE_WIDEN) / (2 pi in Q30)
	localparam longint FK_RECIP = (longint'(1) <<< (FK_RECIP_SH + FK_ANGLE_WIDEN)) / FK_TWO_PI;

	localparam logic [FK_INDEX_BITS-1:0] FK_REG_BASE_HEIGHT     = 3'd0;
	localparam logic [FK_INDEX_BITS-1:0] FK_REG_SHOULDER_OFFSET = 3'd1;
	localparam logic [FK_INDEX_BITS-1:0] FK_REG_UPPER_ARM       = 3'd2;
	localparam logic [FK_INDEX_BITS-1:0] FK_REG_FOREARM         = 3'd3;
	localparam logic [FK_INDEX_BITS-1:0] FK_REG_WRIST_DROP      = 3'd4;
	localparam logic [FK_INDEX_BITS-1:0] FK_REG_TOOL_LENGTH     = 3'd5;

	typedef logic signed [FK_TRIG_W-1:0] trig_t;
	typedef logic signed [FK_POS_W-1:0]  pos_t;
	typedef logic signed [FK_REG_BITS-1:0] len_t;

	// atan(2^-i) in Q30, truncated
	function automatic trig_t fk_atan(input int idx);
		trig_t v;
		case (idx)
			0:  v = 34'sd843314856;
			1:  v = 34'sd497837829;
			2:  v = 34'sd263043836;
			3:  v = 34'sd133525158;
			4:  v = 34'sd67021686;
			5:  v = 34'sd33543515;
			6:  v = 34'sd16775850;
			7:  v = 34'sd8388437;
			8:  v = 34'sd4194282;
			9:  v = 34'sd2097149;
			10: v = 34'sd1048575;
			11: v = 34'sd524287;
			12: v = 34'sd262143;
			13: v = 34'sd131071;
			14: v = 34'sd65535;
			15: v = 34'sd32767;
			16: v = 34'sd16383;
			17: v = 34'sd8191;
			18: v = 34'sd4095;
			19: v = 34'sd2047;
			20: v = 34'sd1023;
			21: v = 34'sd511;
			22: v = 34'sd255;
			23: v = 34'sd127;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/fk_cordic_lane.sv =====
// One sine/cosine lane: angle range reduction followed by a pipelined CORDIC.
module fk_cordic_lane import fk_pkg::*; #(
	parameter int ANGLE_BITS    = FK_ANGLE_BITS,
	parameter int CORDIC_STAGES = FK_CORDIC_STAGES
) (
	input  logic                         clk,
	input  logic                         adv,
	input  logic signed [ANGLE_BITS-1:0] angle,
	output trig_t                        sin_v,
	output trig_t                        cos_v
);

	logic signed [63:0]         kprod;
	logic signed [FK_K_W-1:0]   k_s1;
	logic signed [FK_RED_W-1:0] a_s1;
	logic signed [FK_RED_W-1:0] r_s2;
	logic signed [FK_RED_W-1:0] r_s3;

	trig_t cx_s [0:CORDIC_STAGES];
	trig_t cy_s [0:CORDIC_STAGES];
	trig_t cz_s [0:CORDIC_STAGES];
	logic  cf_s [0:CORDIC_STAGES];

	// nearest turn count, may be off by one at the edges
	always_comb begin
		kprod = 64'(angle) * FK_RECIP + (64'sd1 <<< (FK_RECIP_SH - 1));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			k_s1 <= FK_K_W'(kprod >>> FK_RECIP_SH);
			a_s1 <= FK_RED_W'(angle) <<< FK_ANGLE_WIDEN;
			r_s2 <= a_s1 - FK_RED_W'(k_s1) * FK_RED_W'(FK_TWO_PI);
			if (r_s2 >= FK_RED_W'(FK_PI)) begin
				r_s3 <= r_s2 - FK_RED_W'(FK_TWO_PI);
			end else if (r_s2 < -FK_RED_W'(FK_PI)) begin
				r_s3 <= r_s2 + FK_RED_W'(FK_TWO_PI);
			end else begin
				r_s3 <= r_s2;
			end
			// fold into the right half plane, negating both outputs
			cx_s[0] <= FK_TRIG_W'(FK_GAIN);
			cy_s[0] <= '0;
			if (r_s3 > FK_RED_W'(FK_HALF_PI)) begin
				cz_s[0] <= FK_TRIG_W'(r_s3 - FK_RED_W'(FK_PI));
				cf_s[0] <= 1'b1;
			end else if (r_s3 < -FK_RED_W'(FK_HALF_PI)) begin
				cz_s[0] <= FK_TRIG_W'(r_s3 + FK_RED_W'(FK_PI));
				cf_s[0] <= 1'b1;
			end else begin
				cz_s[0] <= FK_TRIG_W'(r_s3);
				cf_s[0] <= 1'b0;
			end
		end
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		always_ff @(posedge clk) begin
			if (adv) begin
				cf_s[i+1] <= cf_s[i];
				if (cz_s[i] >= 0) begin
					cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] - fk_atan(i);
				end else begin
					cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] + fk_atan(i);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sin_v <= cf_s[CORDIC_STAGES] ? -cy_s[CORDIC_STAGES] : cy_s[CORDIC_STAGES];
			cos_v <= cf_s[CORDIC_STAGES] ? -cx_s[CORDIC_STAGES] : cx_s[CORDIC_STAGES];
		end
	end

endmodule

// ===== rtl/fk_rot_stage.sv =====
// Plane rotation of a position pair by a Q30 sine/cosine, with rounding and offsets.
module fk_rot_stage import fk_pkg::*; (
	input  logic  clk,
	input  logic  adv,
	input  trig_t c,
	input  trig_t s,
	input  pos_t  u,
	input  pos_t  v,
	input  pos_t  add_u,
	input  pos_t  add_v,
	output pos_t  nu,
	output pos_t  nv
);

	localparam int PW = FK_TRIG_W + FK_POS_W + 1;

	logic signed [PW-1:0] cu_s1, sv_s1, su_s1, cv_s1;
	logic signed [PW-1:0] su_sum, sv_sum;
	localparam logic signed [PW-1:0] HALF = PW'(64'sd1 <<< (FK_TRIG_FRAC - 1));

	always_ff @(posedge clk) begin
		if (adv) begin
			cu_s1 <= PW'(c) * PW'(u);
			sv_s1 <= PW'(s) * PW'(v);
			su_s1 <= PW'(s) * PW'(u);
			cv_s1 <= PW'(c) * PW'(v);
		end
	end

	always_comb begin
		su_sum = cu_s1 + sv_s1 + HALF;
		sv_sum = cv_s1 - su_s1 + HALF;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nu <= FK_POS_W'(su_sum >>> FK_TRIG_FRAC) + add_u;
			nv <= FK_POS_W'(sv_sum >>> FK_TRIG_FRAC) + add_v;
		end
	end

endmodule

// ===== rtl/arm_forward_kinematics.sv =====
// Top level of the five-joint arm forward kinematics pipeline.
//
// Takes five joint angles per request (radians * 2^13) and returns the tool tip
// position (metres * 2^17) with a saturation flag. Fully pipelined: one request
// is accepted every clock unless the output stalls. Four CORDIC lanes (base yaw,
// shoulder, elbow, wrist pitch) run side by side, each doing range reduction
// (4 stages), CORDIC_STAGES micro-rotations and an output register; the merge
// chain then applies wrist, elbow, shoulder and yaw rotations, two stages each
// (multiply, round), and a final clamp register. Wrist roll is accepted but
// cannot move the tip. The whole pipe holds when a result waits at the output
// and m_tready is low. The user must write link lengths on the cfg port only
// while no request is in flight; the block itself does not enforce it.
module arm_forward_kinematics import fk_pkg::*; #(
	parameter int ANGLE_BITS    = FK_ANGLE_BITS,
	parameter int POS_BITS      = FK_POS_BITS,
	parameter int CORDIC_STAGES = FK_CORDIC_STAGES
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// base_yaw, shoulder_pitch, elbow_pitch, wrist_pitch, wrist_roll
	input  logic [((5*ANGLE_BITS+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// tip_x, tip_y, tip_z
	output logic [((3*POS_BITS+7)/8)*8-1:0] m_tdata,
	// clipped
	output logic m_tuser,
	input  logic cfg_we,
	input  logic [FK_INDEX_BITS-1:0] cfg_index,
	input  logic [FK_REG_BITS-1:0] cfg_data
);

	localparam int LAT   = CORDIC_STAGES + 14;
	localparam int OUT_W = ((3*POS_BITS+7)/8)*8;

	logic adv;
	logic [LAT-1:0] vld_q;

	len_t base_height_q, shoulder_offset_q, upper_arm_q, forearm_q, wrist_drop_q, tool_q;

	trig_t sin0, cos0, sin1, cos1, sin2, cos2, sin3, cos3;
	trig_t el_c_s [0:1], el_s_s [0:1];
	trig_t sh_c_s [0:3], sh_s_s [0:3];
	trig_t yw_c_s [0:5], yw_s_s [0:5];
	pos_t  z_s [0:1];
	pos_t  wu, wv, eu, ev, su, sv, yu, yv;

	logic signed [63:0] ext_x, ext_y, ext_z, pos_hi, pos_lo;
	logic [POS_BITS-1:0] tx_q, ty_q, tz_q;
	logic clip_q;

	// the pipe moves whenever the output slot is free or being drained
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_height_q     <= 18'sd32768;
			shoulder_offset_q <= 18'sd6554;
			upper_arm_q       <= 18'sd39322;
			forearm_q         <= 18'sd26214;
			wrist_drop_q      <= -18'sd6554;
			tool_q            <= 18'sd19661;
		end else if (cfg_we) begin
			unique case (cfg_index)
				FK_REG_BASE_HEIGHT:     base_height_q     <= cfg_data;
				FK_REG_SHOULDER_OFFSET: shoulder_offset_q <= cfg_data;
				FK_REG_UPPER_ARM:       upper_arm_q       <= cfg_data;
				FK_REG_FOREARM:         forearm_q         <= cfg_data;
				FK_REG_WRIST_DROP:      wrist_drop_q      <= cfg_data;
				FK_REG_TOOL_LENGTH:     tool_q            <= cfg_data;
				default: ;
			endcase
		end
	end

	// lanes: one per moving joint that affects the tip
	fk_cordic_lane #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_lane_yaw (
		.clk(clk), .adv(adv), .angle(s_tdata[0*ANGLE_BITS +: ANGLE_BITS]),
		.sin_v(sin0), .cos_v(cos0));
	fk_cordic_lane #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_lane_sh (
		.clk(clk), .adv(adv), .angle(s_tdata[1*ANGLE_BITS +: ANGLE_BITS]),
		.sin_v(sin1), .cos_v(cos1));
	fk_cordic_lane #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_lane_el (
		.clk(clk), .adv(adv), .angle(s_tdata[2*ANGLE_BITS +: ANGLE_BITS]),
		.sin_v(sin2), .cos_v(cos2));
	fk_cordic_lane #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_lane_wr (
		.clk(clk), .adv(adv), .angle(s_tdata[3*ANGLE_BITS +: ANGLE_BITS]),
		.sin_v(sin3), .cos_v(cos3));

	// hold later joints' trig until their rotation step comes up
	always_ff @(posedge clk) begin
		if (adv) begin
			el_c_s[0] <= cos2; el_s_s[0] <= sin2;
			el_c_s[1] <= el_c_s[0]; el_s_s[1] <= el_s_s[0];
			sh_c_s[0] <= cos1; sh_s_s[0] <= sin1;
			yw_c_s[0] <= cos0; yw_s_s[0] <= sin0;
			for (int i = 1; i < 4; i++) begin
				sh_c_s[i] <= sh_c_s[i-1]; sh_s_s[i] <= sh_s_s[i-1];
			end
			for (int i = 1; i < 6; i++) begin
				yw_c_s[i] <= yw_c_s[i-1]; yw_s_s[i] <= yw_s_s[i-1];
			end
			z_s[0] <= sv;
			z_s[1] <= z_s[0];
		end
	end

	// wrist pitch on (tool, drop), then forearm along x
	fk_rot_stage u_rot_wr (
		.clk(clk), .adv(adv), .c(cos3), .s(sin3),
		.u(FK_POS_W'(tool_q)), .v(FK_POS_W'(wrist_drop_q)),
		.add_u(FK_POS_W'(forearm_q)), .add_v('0), .nu(wu), .nv(wv));

	// elbow pitch, then upper arm along x
	fk_rot_stage u_rot_el (
		.clk(clk), .adv(adv), .c(el_c_s[1]), .s(el_s_s[1]),
		.u(wu), .v(wv), .add_u(FK_POS_W'(upper_arm_q)), .add_v('0), .nu(eu), .nv(ev));

	// shoulder pitch, then base height along z
	fk_rot_stage u_rot_sh (
		.clk(clk), .adv(adv), .c(sh_c_s[3]), .s(sh_s_s[3]),
		.u(eu), .v(ev), .add_u('0), .add_v(FK_POS_W'(base_height_q)), .nu(su), .nv(sv));

	// base yaw on (x, shoulder offset); sine negated for the z axis sense
	fk_rot_stage u_rot_yw (
		.clk(clk), .adv(adv), .c(yw_c_s[5]), .s(-yw_s_s[5]),
		.u(su), .v(FK_POS_W'(shoulder_offset_q)), .add_u('0), .add_v('0), .nu(yu), .nv(yv));

	// saturate to the output width
	always_comb begin
		pos_hi = (64'sd1 <<< (POS_BITS - 1)) - 64'sd1;
		pos_lo = -pos_hi - 64'sd1;
		ext_x  = 64'(yu);
		ext_y  = 64'(yv);
		ext_z  = 64'(z_s[1]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tx_q <= POS_BITS'(ext_x > pos_hi ? pos_hi : (ext_x < pos_lo ? pos_lo : ext_x));
			ty_q <= POS_BITS'(ext_y > pos_hi ? pos_hi : (ext_y < pos_lo ? pos_lo : ext_y));
			tz_q <= POS_BITS'(ext_z > pos_hi ? pos_hi : (ext_z < pos_lo ? pos_lo : ext_z));
			clip_q <= (ext_x > pos_hi) || (ext_x < pos_lo) || (ext_y > pos_hi) ||
				(ext_y < pos_lo) || (ext_z > pos_hi) || (ext_z < pos_lo);
		end
	end

	assign m_tdata = OUT_W'({tz_q, ty_q, tx_q});
	assign m_tuser = clip_q;

endmodule

// ===== dv/tb_arm_forward_kinematics.sv =====
// Self-checking testbench for the arm forward kinematics pipeline.
`timescale 1ns / 100ps

module tb_arm_forward_kinematics;
	import fk_pkg::*;

	localparam int AB = FK_ANGLE_BITS;
	localparam int PB = FK_POS_BITS;
	localparam int SW = ((5*AB+7)/8)*8;
	localparam int MW = ((3*PB+7)/8)*8;
	localparam int LATENCY = FK_CORDIC_STAGES + 14;
	localparam longint CYCLE_LIMIT = 400000;
	localparam int N_RANDOM = 1100;

	// indexes past the last link register
	localparam logic [FK_INDEX_BITS-1:0] IDX_SPARE_LO = 3'd6;
	localparam logic [FK_INDEX_BITS-1:0] IDX_SPARE_HI = 3'd7;

	// joint angles of one request
	typedef struct packed {
		logic signed [AB-1:0] roll;
		logic signed [AB-1:0] wrist;
		logic signed [AB-1:0] elbow;
		logic signed [AB-1:0] shoulder;
		logic signed [AB-1:0] yaw;
	} joints_t;

	typedef struct {
		logic signed [PB-1:0] x;
		logic signed [PB-1:0] y;
		logic signed [PB-1:0] z;
		logic                 clip;
	} tip_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [SW-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [MW-1:0] m_tdata;
	logic m_tuser;
	logic cfg_we = 1'b0;
	logic [FK_INDEX_BITS-1:0] cfg_index = '0;
	logic [FK_REG_BITS-1:0] cfg_data = '0;

	arm_forward_kinematics dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// local copy of the link lengths
	longint link_len [6];
	tip_t pending_tips [$];
	int errors = 0;
	longint cycles = 0;

	longint atan_tab [FK_MAX_STAGES] = '{
		843314856, 497837829, 263043836, 133525158, 67021686,
		33543515, 16775850, 8388437, 4194282, 2097149,
		1048575, 524287, 262143, 131071, 65535, 32767,
		16383, 8191, 4095, 2047, 1023, 511, 255, 127};

	// >>> on longint is arithmetic, i.e. a floor shift
	function automatic longint rshift_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic void cordic_sincos(longint raw, output longint sn, output longint cs);
		longint a, x, y, z, nx, dx, dy;
		bit flip;
		a = raw * (longint'(1) << FK_ANGLE_WIDEN);
		a = a % FK_TWO_PI;
		if (a >= FK_PI) a -= FK_TWO_PI;
		if (a < -FK_PI) a += FK_TWO_PI;
		flip = 1'b0;
		if (a > FK_HALF_PI) begin
			a -= FK_PI;
			flip = 1'b1;
		end else if (a < -FK_HALF_PI) begin
			a += FK_PI;
			flip = 1'b1;
		end
		x = FK_GAIN;
		y = 0;
		z = a;
		for (int i = 0; i < FK_CORDIC_STAGES && i < FK_MAX_STAGES; i++) begin
			dx = rshift_floor(y, i);
			dy = rshift_floor(x, i);
			if (z >= 0) begin
				nx = x - dx; y = y + dy; z -= atan_tab[i];
			end else begin
				nx = x + dx; y = y - dy; z += atan_tab[i];
			end
			x = nx;
		end
		sn = flip ? -y : y;
		cs = flip ? -x : x;
	endfunction

	function automatic longint mac_round(longint a, longint b, longint c, longint d);
		return rshift_floor(a*b + c*d + (longint'(1) << (FK_TRIG_FRAC-1)), FK_TRIG_FRAC);
	endfunction

	function automatic void pitch_turn(longint ang, inout longint px, inout longint pz);
		longint s, c, nx;
		cordic_sincos(ang, s, c);
		nx = mac_round(c, px, s, pz);
		pz = mac_round(-s, px, c, pz);
		px = nx;
	endfunction

	function automatic longint clamp_pos(longint v, inout logic clip);
		longint hi, lo;
		hi = (longint'(1) << (PB-1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			v = hi; clip = 1'b1;
		end
		if (v < lo) begin
			v = lo; clip = 1'b1;
		end
		return v;
	endfunction

	function automatic tip_t tip_position(joints_t j);
		longint px, py, pz, s, c, nx;
		tip_t t;
		t.clip = 1'b0;
		px = link_len[FK_REG_TOOL_LENGTH];
		py = 0;
		pz = link_len[FK_REG_WRIST_DROP];
		pitch_turn(longint'(j.wrist), px, pz);
		px += link_len[FK_REG_FOREARM];
		pitch_turn(longint'(j.elbow), px, pz);
		px += link_len[FK_REG_UPPER_ARM];
		pitch_turn(longint'(j.shoulder), px, pz);
		py += link_len[FK_REG_SHOULDER_OFFSET];
		pz += link_len[FK_REG_BASE_HEIGHT];
		cordic_sincos(longint'(j.yaw), s, c);
		nx = mac_round(c, px, -s, py);
		py = mac_round(s, px, c, py);
		px = nx;
		t.x = PB'(clamp_pos(px, t.clip));
		t.y = PB'(clamp_pos(py, t.clip));
		t.z = PB'(clamp_pos(pz, t.clip));
		return t;
	endfunction

	// short idle most of the time, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// cycle counter and watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t timeout", $time);
			$display("arm_forward_kinematics: mismatch");
			$finish;
		end
	end

	// result side: random stalls, compare against oldest expectation
	int out_gap = 0;
	always @(posedge clk) begin
		tip_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.x = m_tdata[PB-1:0];
			got.y = m_tdata[2*PB-1:PB];
			got.z = m_tdata[3*PB-1:2*PB];
			got.clip = m_tuser;
			if (pending_tips.size() == 0) begin
				$display("%0t unexpected result x=%0d y=%0d z=%0d clip=%0b",
					$time, got.x, got.y, got.z, got.clip);
				errors++;
			end else begin
				want = pending_tips.pop_front();
				if (got.x !== want.x) begin
					$display("%0t tip_x exp %0d got %0d", $time, want.x, got.x);
					errors++;
				end
				if (got.y !== want.y) begin
					$display("%0t tip_y exp %0d got %0d", $time, want.y, got.y);
					errors++;
				end
				if (got.z !== want.z) begin
					$display("%0t tip_z exp %0d got %0d", $time, want.z, got.z);
					errors++;
				end
				if (got.clip !== want.clip) begin
					$display("%0t clipped exp %0b got %0b", $time, want.clip, got.clip);
					errors++;
				end
			end
		end
		if (!arst_n) begin
			out_gap = 0;
			m_tready <= 1'b0;
		end else if (out_gap != 0) begin
			out_gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 3) == 0) out_gap = gap_len();
		end
	end

	task automatic write_link(input logic [FK_INDEX_BITS-1:0] idx, input longint val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[FK_REG_BITS-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx <= FK_REG_TOOL_LENGTH)
			link_len[idx] = longint'(signed'(val[FK_REG_BITS-1:0]));
	endtask

	task automatic drain();
		while (pending_tips.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// one request; held until accepted, next may follow back to back
	task automatic send_joints(input joints_t j, input bit fix_check, input tip_t fixed_tip);
		int g;
		g = gap_len();
		if (g != 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= SW'(j);
		pending_tips.push_back(fix_check ? fixed_tip : tip_position(j));
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	function automatic logic signed [AB-1:0] rand_angle();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return {1'b1, {(AB-1){1'b0}}};
		if (r == 1) return {1'b0, {(AB-1){1'b1}}};
		if (r < 5) return AB'($signed($urandom_range(0, 25736)) - 12868);
		return AB'($urandom);
	endfunction

	function automatic joints_t rand_joints();
		joints_t j;
		j.yaw = rand_angle();
		j.shoulder = rand_angle();
		j.elbow = rand_angle();
		j.wrist = rand_angle();
		j.roll = AB'($urandom);
		return j;
	endfunction

	// directed rows; a fixed tip is given only where it is obvious
	typedef struct {
		joints_t j;
		bit      fixed;
		tip_t    t;
	} row_t;

	localparam logic signed [AB-1:0] AMAX = {1'b0, {(AB-1){1'b1}}};
	localparam logic signed [AB-1:0] AMIN = {1'b1, {(AB-1){1'b0}}};
	localparam logic signed [AB-1:0] HALFPI = 12868;
	localparam logic signed [AB-1:0] PI_A = 25736;

	initial begin
		row_t rows [$];
		tip_t none;
		longint v;
		none = '{x: 0, y: 0, z: 0, clip: 0};
		link_len = '{32768, 6554, 39322, 26214, -6554, 19661};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset lengths, zero / extreme / quadrant angles, roll only
		rows.push_back('{'{0, 0, 0, 0, 0}, 0, none});
		rows.push_back('{'{AMAX, 0, 0, 0, 0}, 0, none});
		rows.push_back('{'{AMIN, AMIN, AMIN, AMIN, AMIN}, 0, none});
		rows.push_back('{'{AMAX, AMAX, AMAX, AMAX, AMAX}, 0, none});
		rows.push_back('{'{0, 0, 0, 0, HALFPI}, 0, none});
		rows.push_back('{'{0, 0, 0, HALFPI, 0}, 0, none});
		rows.push_back('{'{0, 0, HALFPI, 0, 0}, 0, none});
		rows.push_back('{'{0, HALFPI, 0, 0, 0}, 0, none});
		rows.push_back('{'{0, 0, 0, -HALFPI, -HALFPI}, 0, none});
		rows.push_back('{'{0, PI_A, PI_A, PI_A, PI_A}, 0, none});
		rows.push_back('{'{AMIN, -PI_A, -PI_A, -PI_A, -PI_A}, 0, none});
		rows.push_back('{'{16'h5555, 16'h2aaa, 16'h5555, 16'h2aaa, 16'h5555}, 0, none});
		foreach (rows[i]) send_joints(rows[i].j, rows[i].fixed, rows[i].t);
		s_tvalid <= 1'b0;
		drain();

		// all lengths zero: tip is at the origin whatever the angles
		for (int k = 0; k <= FK_REG_TOOL_LENGTH; k++) write_link(FK_INDEX_BITS'(k), 0);
		write_link(IDX_SPARE_HI, 64'h1ffff); // index beyond the register set is ignored
		write_link(IDX_SPARE_LO, 64'h1ffff);
		send_joints('{AMAX, AMIN, AMAX, AMIN, 16'h1234}, 1, none);
		send_joints('{0, 0, 0, 0, 0}, 1, none);
		s_tvalid <= 1'b0;
		drain();

		// all lengths at max, then at min
		for (int k = 0; k <= FK_REG_TOOL_LENGTH; k++) write_link(FK_INDEX_BITS'(k), 131071);
		send_joints('{0, 0, 0, 0, 0}, 0, none);
		send_joints('{AMAX, HALFPI, 0, 0, 0}, 0, none);
		s_tvalid <= 1'b0;
		drain();
		for (int k = 0; k <= FK_REG_TOOL_LENGTH; k++) write_link(FK_INDEX_BITS'(k), -131072);
		send_joints('{0, 0, 0, 0, 0}, 0, none);
		send_joints('{AMIN, PI_A, HALFPI, 0, 0}, 0, none);
		s_tvalid <= 1'b0;
		drain();

		// random phases, each under new lengths; first phase back at reset values
		for (int ph = 0; ph < 8; ph++) begin
			for (int k = 0; k <= FK_REG_TOOL_LENGTH; k++) begin
				case (ph)
					0: v = (k == 0) ? 32768 : (k == 1) ? 6554 : (k == 2) ? 39322 :
						(k == 3) ? 26214 : (k == 4) ? -6554 : 19661;
					1, 2: v = $signed($urandom_range(0, 131071)) - 65536;
					default: v = longint'($signed(18'($urandom)));
				endcase
				write_link(FK_INDEX_BITS'(k), v);
			end
			for (int n = 0; n < N_RANDOM / 8; n++)
				send_joints(rand_joints(), 0, none);
			s_tvalid <= 1'b0;
			drain();
		end

		if (errors == 0)
			$display("arm_forward_kinematics: match");
		else
			$display("arm_forward_kinematics: mismatch");
		$finish;
	end

endmodule
